[hdl/dps_pkg.sv]
// Shared widths, status codes and controller/datapath handshake types.
package dps_pkg;

    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 16;
    localparam int OUT_ID_W = 8;
    localparam int OUT_CNT_W = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic exec;      // create: insert or reject; run: pop the head
        logic reins;     // put the popped entry back with its priority lowered (held at the minimum)
        logic load_out;  // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_reins;
    } t_dp_sts;

endpackage

[hdl/dynamic_priority_scheduler_top.sv]
// Top level of the dynamic priority scheduler.
//
// The input channel carries one request per transfer (i_valid / o_stall):
// mode 0 creates a process entry from proc_id, priority_req and run_time;
// mode 1 runs one time slice of the head entry. The output channel
// (o_valid / i_stall) returns exactly one result per request, in order.
//
// A request is taken only when the block is idle. A create, a run on an
// empty queue and a run that finishes its process load the result register
// from the execute state; a run that puts its process back loads it from
// the reinsertion state that follows, which reinserts the entry into the
// sorted shift queue. The next request can be accepted in the cycle after
// the result is loaded, even while that result is still waiting at the
// output.
//
// If the receiver stalls, the result register holds and the block waits
// before touching the queue for the next request. Reset (synchronous,
// active low) empties the queue and drops any pending result; queue
// contents need no clearing pass.
module dynamic_priority_scheduler_top
    import dps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic [OUT_ID_W-1:0]      i_proc_id,
    input  logic signed [PRIO_W-1:0] i_priority_req,
    input  logic [TIME_W-1:0]        i_run_time,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic [OUT_ID_W-1:0]      o_ran_id,
    output logic signed [PRIO_W-1:0] o_ran_priority,
    output logic [TIME_W-1:0]        o_ran_elapsed,
    output logic                     o_finished,
    output logic [OUT_CNT_W-1:0]     o_queue_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dps_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .i_run_time     (i_run_time),
        .o_status       (o_status),
        .o_ran_id       (o_ran_id),
        .o_ran_priority (o_ran_priority),
        .o_ran_elapsed  (o_ran_elapsed),
        .o_finished     (o_finished),
        .o_queue_count  (o_queue_count)
    );

endmodule

[hdl/dps_ctrl.sv]
// Controller state machine for the priority scheduler.
module dps_ctrl
    import dps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_REINS = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // Each step waits until the result register can take its
                // result, so the queue is only touched once per step.
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.needs_reins) begin
                        n_state = S_REINS;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_REINS: begin
                if (out_free) begin
                    o_cmd.reins    = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EXEC))
        else $error("accepted request did not start execution");

    a_reins_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REINS) && !$past(r_state == S_REINS)) |-> $past(r_state == S_EXEC))
        else $error("reinsertion entered from a state other than execute");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EXEC || r_state == S_REINS))
        else $error("result appeared without a finishing step");

endmodule

[hdl/dps_datapath.sv]
// Sorted shift queue, request and result registers of the priority scheduler.
module dps_datapath
    import dps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic                     i_mode,
    input  logic [OUT_ID_W-1:0]      i_proc_id,
    input  logic signed [PRIO_W-1:0] i_priority_req,
    input  logic [TIME_W-1:0]        i_run_time,
    output logic [1:0]               o_status,
    output logic [OUT_ID_W-1:0]      o_ran_id,
    output logic signed [PRIO_W-1:0] o_ran_priority,
    output logic [TIME_W-1:0]        o_ran_elapsed,
    output logic                     o_finished,
    output logic [OUT_CNT_W-1:0]     o_queue_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Queue cells; cell 0 is the head.
    logic [ID_WIDTH-1:0]      r_q_id   [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] r_q_prio [QUEUE_DEPTH];
    logic [TIME_W-1:0]        r_q_need [QUEUE_DEPTH];
    logic [TIME_W-1:0]        r_q_el   [QUEUE_DEPTH];
    logic [CW-1:0]            r_count, n_count;

    // Accepted request.
    logic                     r_mode;
    logic [ID_WIDTH-1:0]      r_id;
    logic signed [PRIO_W-1:0] r_prio;
    logic [TIME_W-1:0]        r_need;

    // Entry popped by a run slice, waiting for reinsertion.
    logic [ID_WIDTH-1:0]      r_h_id;
    logic signed [PRIO_W-1:0] r_h_prio;
    logic [TIME_W-1:0]        r_h_need;
    logic [TIME_W-1:0]        r_h_el;

    // Result register.
    logic [1:0]               r_o_status;
    logic [OUT_ID_W-1:0]      r_o_id;
    logic signed [PRIO_W-1:0] r_o_prio;
    logic [TIME_W-1:0]        r_o_el;
    logic                     r_o_fin;
    logic [OUT_CNT_W-1:0]     r_o_cnt;

    logic [ID_WIDTH+OUT_ID_W-1:0]  in_id_ext;
    logic [ID_WIDTH+OUT_ID_W-1:0]  head_id_ext;
    logic [ID_WIDTH+OUT_ID_W-1:0]  hold_id_ext;
    logic [CW+OUT_CNT_W-1:0]       cnt_ext;

    logic                     is_empty, is_full;
    logic [TIME_W-1:0]        head_el_inc;
    logic                     create_ok, do_insert, do_pop;
    logic [ID_WIDTH-1:0]      ins_id;
    logic signed [PRIO_W-1:0] ins_prio;
    logic [TIME_W-1:0]        ins_need, ins_el;
    logic signed [PRIO_W-1:0] h_prio_dec;
    logic [QUEUE_DEPTH-1:0]   take;

    logic [1:0]               res_status;
    logic [OUT_ID_W-1:0]      res_id;
    logic signed [PRIO_W-1:0] res_prio;
    logic [TIME_W-1:0]        res_el;
    logic                     res_fin;

    assign in_id_ext   = {{ID_WIDTH{1'b0}}, i_proc_id};
    assign head_id_ext = {{OUT_ID_W{1'b0}}, r_q_id[0]};
    assign hold_id_ext = {{OUT_ID_W{1'b0}}, r_h_id};
    assign cnt_ext     = {{OUT_CNT_W{1'b0}}, n_count};

    assign is_empty    = (r_count == '0);
    assign is_full     = (r_count == CW'(QUEUE_DEPTH));
    assign head_el_inc = r_q_el[0] + TIME_W'(1);

    assign o_sts.needs_reins = r_mode && !is_empty && (head_el_inc != r_q_need[0]);

    assign create_ok = !r_mode && !is_full && (r_need != '0);
    assign do_insert = (i_cmd.exec && create_ok) || i_cmd.reins;
    assign do_pop    = i_cmd.exec && r_mode && !is_empty;

    assign h_prio_dec = (r_h_prio == PRIO_MIN) ? r_h_prio : r_h_prio - PRIO_W'(1);

    assign ins_id   = i_cmd.reins ? r_h_id     : r_id;
    assign ins_prio = i_cmd.reins ? h_prio_dec : r_prio;
    assign ins_need = i_cmd.reins ? r_h_need   : r_need;
    assign ins_el   = i_cmd.reins ? r_h_el     : '0;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_id   <= in_id_ext[ID_WIDTH-1:0];
            r_prio <= i_priority_req;
            r_need <= i_run_time;
        end
    end

    // Hold register for the entry that just ran.
    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_h_id   <= r_q_id[0];
            r_h_prio <= r_q_prio[0];
            r_h_need <= r_q_need[0];
            r_h_el   <= head_el_inc;
        end
    end

    // Each cell decides on its own: a new entry lands in the first cell
    // whose priority it beats (or the first empty cell), and the cells
    // behind it shift down by one. Equal priorities are not beaten, so the
    // newcomer goes behind them.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic take_prev;

            assign take[g] = (CW'(g) >= r_count) || (ins_prio > r_q_prio[g]);

            if (g == 0) begin : g_first
                assign take_prev = 1'b0;
            end else begin : g_rest
                assign take_prev = take[g-1];
            end

            always_ff @(posedge i_clk) begin
                if (do_pop) begin
                    if (g < QUEUE_DEPTH - 1) begin
                        r_q_id[g]   <= r_q_id[(g+1) % QUEUE_DEPTH];
                        r_q_prio[g] <= r_q_prio[(g+1) % QUEUE_DEPTH];
                        r_q_need[g] <= r_q_need[(g+1) % QUEUE_DEPTH];
                        r_q_el[g]   <= r_q_el[(g+1) % QUEUE_DEPTH];
                    end
                end else if (do_insert && take[g]) begin
                    if (!take_prev) begin
                        r_q_id[g]   <= ins_id;
                        r_q_prio[g] <= ins_prio;
                        r_q_need[g] <= ins_need;
                        r_q_el[g]   <= ins_el;
                    end else begin
                        r_q_id[g]   <= r_q_id[(g+QUEUE_DEPTH-1) % QUEUE_DEPTH];
                        r_q_prio[g] <= r_q_prio[(g+QUEUE_DEPTH-1) % QUEUE_DEPTH];
                        r_q_need[g] <= r_q_need[(g+QUEUE_DEPTH-1) % QUEUE_DEPTH];
                        r_q_el[g]   <= r_q_el[(g+QUEUE_DEPTH-1) % QUEUE_DEPTH];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        if (do_pop) begin
            n_count = r_count - CW'(1);
        end else if (do_insert) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result of the step that finishes the request.
    always_comb begin
        res_status = ST_OK;
        res_id     = '0;
        res_prio   = '0;
        res_el     = '0;
        res_fin    = 1'b0;
        if (i_cmd.reins) begin
            res_id   = hold_id_ext[OUT_ID_W-1:0];
            res_prio = r_h_prio;
            res_el   = r_h_el;
        end else if (!r_mode) begin
            if (is_full) begin
                res_status = ST_FULL;
            end else if (r_need == '0) begin
                res_status = ST_ZERO;
            end
        end else if (is_empty) begin
            res_status = ST_EMPTY;
        end else begin
            // A run that needs no reinsertion is one that just finished.
            res_id   = head_id_ext[OUT_ID_W-1:0];
            res_prio = r_q_prio[0];
            res_el   = head_el_inc;
            res_fin  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= res_status;
            r_o_id     <= res_id;
            r_o_prio   <= res_prio;
            r_o_el     <= res_el;
            r_o_fin    <= res_fin;
            r_o_cnt    <= cnt_ext[OUT_CNT_W-1:0];
        end
    end

    assign o_status       = r_o_status;
    assign o_ran_id       = r_o_id;
    assign o_ran_priority = r_o_prio;
    assign o_ran_elapsed  = r_o_el;
    assign o_finished     = r_o_fin;
    assign o_queue_count  = r_o_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_no_pop_and_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_pop && do_insert))
        else $error("pop and insert in the same cycle");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (r_q_prio[0] >= r_q_prio[1 % QUEUE_DEPTH]))
        else $error("queue head is not the highest priority");

endmodule
